// File: rtl/kped_pkg.sv
// ----------------------------------------------------------------------------
// kped_pkg: shared definitions for the key press event detector
// Key count, field widths, event codes and the detector mode type.
// ----------------------------------------------------------------------------
package kped_pkg;

   // key and field widths
   localparam int KEY_COUNT = 6;
   localparam int PIN_W     = 6;
   localparam int KIND_W    = 2;
   localparam int CNT_W     = 16;
   localparam int TDATA_W   = 8;

   // keys that live on the pins, clipped to the pin field
   localparam logic [PIN_W-1:0] ALL_KEYS =
      PIN_W'(((32'd1 << KEY_COUNT) - 32'd1) & 32'h3F);

   // key 4 and key 5 take part in the combined long press
   localparam logic [PIN_W-1:0] KEY4_BIT  = PIN_W'(6'h08);
   localparam logic [PIN_W-1:0] KEY5_BIT  = PIN_W'(6'h10);
   localparam logic [PIN_W-1:0] COMBO_SET = KEY4_BIT | KEY5_BIT;

   // long press threshold after reset
   localparam logic [CNT_W-1:0] LONG_TICKS_RESET = CNT_W'(150);

   // event codes on the result channel
   localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
   localparam logic [KIND_W-1:0] EV_DOWN = 2'd1;
   localparam logic [KIND_W-1:0] EV_UP   = 2'd2;
   localparam logic [KIND_W-1:0] EV_LONG = 2'd3;

   // detector modes
   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_CANDIDATE = 3'd1,
      MODE_HOLD      = 3'd2,
      MODE_COMBO     = 3'd3,
      MODE_WAIT      = 3'd4
   } mode_type;

endpackage

// File: rtl/key_press_event_detector.sv
// ----------------------------------------------------------------------------
// key_press_event_detector: debounced key down, key up and long press events
// Each accepted word updates mode, pattern and hold counter in one pass; its result is registered.
// Throughput: one word per cycle while the result slot is free or draining.
// Reset: mode idle, pattern and counter cleared, threshold 150, no result held.
// ----------------------------------------------------------------------------
module key_press_event_detector (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kped_pkg::TDATA_W-1:0]    req_tdata,   // [5:0] pin_levels
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kped_pkg::TDATA_W-1:0]    rsp_tdata,   // [5:0] key_mask
   output logic [kped_pkg::KIND_W-1:0]     rsp_tuser,   // [1:0] event_kind
   // configuration
   input  logic                            csr_wr_en,
   input  logic [kped_pkg::CNT_W-1:0]      csr_wr_data  // long_press_ticks
);
   import kped_pkg::*;

   // registers
   logic [CNT_W-1:0]  long_ticks_ff;
   mode_type          mode_ff, mode_in;
   logic [PIN_W-1:0]  first_ff, first_in;
   logic [CNT_W-1:0]  hold_cnt_ff, hold_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [PIN_W-1:0]  rsp_mask_ff, rsp_mask_in;

   // combinational helpers
   logic              accept;
   logic [PIN_W-1:0]  pressed;
   logic [CNT_W-1:0]  cnt_inc;
   logic              cnt_reached;
   logic              same_pat;
   logic              has_combo_key;
   logic              is_zero;
   logic [KIND_W-1:0] ev_kind;
   logic [PIN_W-1:0]  ev_mask;

   // handshake: take a word whenever the result slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // pressed mask from active-low pins
   assign pressed       = ~req_tdata[PIN_W-1:0] & ALL_KEYS;
   assign same_pat      = (pressed == first_ff);
   assign has_combo_key = ((pressed & COMBO_SET) != '0);
   assign is_zero       = (pressed == '0);

   // hold counter wraps at its width
   assign cnt_inc     = hold_cnt_ff + CNT_W'(1);
   assign cnt_reached = (cnt_inc >= long_ticks_ff);

   // next state
   always_comb begin
      mode_in     = mode_ff;
      first_in    = first_ff;
      hold_cnt_in = hold_cnt_ff;
      unique case (mode_ff)
         MODE_CANDIDATE: begin
            if (same_pat) begin
               if (first_ff == KEY4_BIT || first_ff == KEY5_BIT) begin
                  mode_in = MODE_COMBO;
               end else begin
                  mode_in = MODE_HOLD;
               end
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_HOLD: begin
            if (is_zero) begin
               mode_in     = MODE_IDLE;
               hold_cnt_in = '0;
            end else if (same_pat) begin
               hold_cnt_in = cnt_reached ? '0 : cnt_inc;
               if (cnt_reached) begin
                  mode_in = MODE_WAIT;
               end
            end
         end
         MODE_COMBO: begin
            if (same_pat || has_combo_key) begin
               hold_cnt_in = cnt_reached ? '0 : cnt_inc;
               if (cnt_reached) begin
                  mode_in = MODE_WAIT;
               end
            end else if (is_zero) begin
               mode_in     = MODE_IDLE;
               hold_cnt_in = '0;
            end
         end
         MODE_WAIT: begin
            if (!same_pat) begin
               mode_in     = MODE_IDLE;
               hold_cnt_in = '0;
            end
         end
         default: begin
            if (!is_zero) begin
               first_in = pressed;
               mode_in  = MODE_CANDIDATE;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
      endcase
   end

   // event outputs
   always_comb begin
      ev_kind = EV_NONE;
      ev_mask = '0;
      unique case (mode_ff)
         MODE_CANDIDATE: begin
            if (same_pat) begin
               ev_kind = EV_DOWN;
               ev_mask = first_ff;
            end
         end
         MODE_HOLD: begin
            if (is_zero) begin
               ev_kind = EV_UP;
               ev_mask = first_ff;
            end else if (same_pat && cnt_reached) begin
               ev_kind = EV_LONG;
               ev_mask = pressed;
            end
         end
         MODE_COMBO: begin
            if (same_pat) begin
               if (cnt_reached) begin
                  ev_kind = EV_LONG;
                  ev_mask = pressed;
               end
            end else if (has_combo_key) begin
               if (cnt_reached) begin
                  ev_kind = EV_LONG;
                  ev_mask = COMBO_SET;
               end
            end else if (is_zero) begin
               ev_kind = EV_UP;
               ev_mask = first_ff;
            end
         end
         default: begin
            ev_kind = EV_NONE;
            ev_mask = '0;
         end
      endcase
   end

   // result slot next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_mask_in  = rsp_mask_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = ev_kind;
         rsp_mask_in  = ev_mask;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= LONG_TICKS_RESET;
         mode_ff       <= MODE_IDLE;
         first_ff      <= '0;
         hold_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            long_ticks_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff     <= mode_in;
            first_ff    <= first_in;
            hold_cnt_ff <= hold_cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   // port drive
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(TDATA_W-PIN_W){1'b0}}, rsp_mask_ff};

   // checks
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (mode_ff == MODE_IDLE) && !rsp_valid_ff)
      else $error("reset did not clear mode or result slot");

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (hold_cnt_ff == '0))
      else $error("hold counter nonzero in idle");

   a_candidate_pattern: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CANDIDATE) |-> (first_ff != '0))
      else $error("candidate with empty pattern");

   a_long_to_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && ev_kind == EV_LONG) |=> (mode_ff == MODE_WAIT) && (hold_cnt_ff == '0))
      else $error("long press did not enter wait");

   a_none_mask_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == EV_NONE) |-> (rsp_mask_ff == '0))
      else $error("mask set without event");

endmodule
